>>> rtl/mcph_pkg.sv
// Shared constants, types and helpers of the metric check / hop distance block.
`default_nettype none
package mcph_pkg;
   localparam int MAX_NODES = 64;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = NODE_W + 1;
   localparam int CELL_W    = 2 * NODE_W;
   localparam int CELLS     = MAX_NODES * MAX_NODES;
   localparam int LAT_WIDTH = 16;
   localparam int FUNC_W    = 2;
   localparam int DIST_W    = 7;
   localparam int CFG_W     = 7;

   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SOLVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic [DIST_W-1:0] DIST_NONE = '1;        // -1
   localparam logic [DIST_W-1:0] HOP_MAX   = 7'd63;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
   } eng_ctl_type;

   typedef struct packed {
      logic done;
      logic ok;
   } eng_sts_type;

   // lower-triangle cell of a symmetric pair: {larger, smaller}
   function automatic logic [CELL_W-1:0] lat_cell(input logic [NODE_W-1:0] a,
                                                  input logic [NODE_W-1:0] b);
      lat_cell = (a > b) ? {a, b} : {b, a};
   endfunction
endpackage
`default_nettype wire

>>> rtl/mcph_req_if.sv
// Request channel: valid/ready plus request payload.
`default_nettype none
interface mcph_req_if import mcph_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [LAT_WIDTH-1:0] latency;
   logic [NODE_W-1:0]    source_node;
   logic [NODE_W-1:0]    target_node;

   modport source (output valid, func, latency, source_node, target_node, input ready);
   modport sink   (input valid, func, latency, source_node, target_node, output ready);
endinterface
`default_nettype wire

>>> rtl/mcph_rsp_if.sv
// Response channel: valid/ready plus response payload.
`default_nettype none
interface mcph_rsp_if import mcph_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     possible;
   logic signed [DIST_W-1:0] distance;

   modport source (output valid, possible, distance, input ready);
   modport sink   (input valid, possible, distance, output ready);
endinterface
`default_nettype wire

>>> rtl/mcph_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none
module mcph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/mcph_prune.sv
// Triple sweep: triangle-inequality check and two-hop edge pruning.
`default_nettype none
module mcph_prune import mcph_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire eng_ctl_type          ctl,
   output eng_sts_type               sts,
   output logic [CELL_W-1:0]         lat_a_addr,
   input  wire logic [LAT_WIDTH-1:0] lat_a_data,
   output logic [CELL_W-1:0]         lat_b_addr,
   input  wire logic [LAT_WIDTH-1:0] lat_b_data,
   output logic                      edge_we,
   output logic [CELL_W-1:0]         edge_addr,
   output logic                      edge_data
);
   localparam logic [1:0] P_IDLE = 2'd0;
   localparam logic [1:0] P_IJ   = 2'd1;
   localparam logic [1:0] P_K    = 2'd2;
   localparam logic [1:0] P_END  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [NODE_W-1:0]    i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic                 ev_ff, ev_in, cap_ff, cap_in;
   logic                 kx_ff, kx_in, zik_ff, zik_in, zkj_ff, zkj_in;
   logic [LAT_WIDTH-1:0] lat_ij_ff, lat_ij_in;
   logic                 viol_ff, viol_in, eq_ff, eq_in;
   logic                 done_ff, done_in, ok_ff, ok_in;

   logic [LAT_WIDTH-1:0] v_ij, v_ik, v_kj;
   logic [LAT_WIDTH:0]   sum;
   logic                 viol_now, eq_now, i_last, j_last, k_last;

   assign v_ij     = (i_ff == j_ff) ? '0 : lat_ij_ff;
   assign v_ik     = zik_ff ? '0 : lat_a_data;
   assign v_kj     = zkj_ff ? '0 : lat_b_data;
   assign sum      = {1'b0, v_ik} + {1'b0, v_kj};
   assign viol_now = ev_ff && ({1'b0, v_ij} > sum);
   assign eq_now   = ev_ff && !kx_ff && ({1'b0, v_ij} == sum);

   assign i_last = ({1'b0, i_ff} == n_ff - CNT_W'(1));
   assign j_last = ({1'b0, j_ff} == n_ff - CNT_W'(1));
   assign k_last = ({1'b0, k_ff} == n_ff - CNT_W'(1));

   assign sts.done = done_ff;
   assign sts.ok   = ok_ff;

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      n_in       = n_ff;
      ev_in      = 1'b0;
      cap_in     = 1'b0;
      kx_in      = kx_ff;
      zik_in     = zik_ff;
      zkj_in     = zkj_ff;
      lat_ij_in  = lat_ij_ff;
      viol_in    = viol_ff || viol_now;
      eq_in      = eq_ff || eq_now;
      done_in    = 1'b0;
      ok_in      = ok_ff;
      lat_a_addr = lat_cell(i_ff, k_ff);
      lat_b_addr = lat_cell(k_ff, j_ff);
      edge_we    = 1'b0;
      edge_addr  = {i_ff, j_ff};
      edge_data  = (i_ff != j_ff) && !(eq_ff || eq_now);
      unique case (state_ff)
         P_IDLE: begin
            if (ctl.start) begin
               n_in     = ctl.count;
               i_in     = '0;
               j_in     = '0;
               viol_in  = 1'b0;
               eq_in    = 1'b0;
               state_in = P_IJ;
            end
         end
         P_IJ: begin
            lat_a_addr = lat_cell(i_ff, j_ff);
            cap_in     = 1'b1;
            k_in       = '0;
            state_in   = P_K;
         end
         P_K: begin
            if (cap_ff) begin
               lat_ij_in = lat_a_data;
            end
            ev_in  = 1'b1;
            kx_in  = (k_ff == i_ff) || (k_ff == j_ff);
            zik_in = (k_ff == i_ff);
            zkj_in = (k_ff == j_ff);
            if (k_last) begin
               state_in = P_END;
            end else begin
               k_in = k_ff + NODE_W'(1);
            end
         end
         default: begin
            // last k evaluates here; commit the edge of pair (i,j)
            edge_we = 1'b1;
            eq_in   = 1'b0;
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  done_in  = 1'b1;
                  ok_in    = !(viol_ff || viol_now);
                  state_in = P_IDLE;
               end else begin
                  i_in     = i_ff + NODE_W'(1);
                  state_in = P_IJ;
               end
            end else begin
               j_in     = j_ff + NODE_W'(1);
               state_in = P_IJ;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         ev_ff    <= 1'b0;
         cap_ff   <= 1'b0;
         done_ff  <= 1'b0;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ev_ff    <= ev_in;
         cap_ff   <= cap_in;
         done_ff  <= done_in;
         ok_ff    <= ok_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      n_ff      <= n_in;
      kx_ff     <= kx_in;
      zik_ff    <= zik_in;
      zkj_ff    <= zkj_in;
      lat_ij_ff <= lat_ij_in;
      viol_ff   <= viol_in;
      eq_ff     <= eq_in;
   end
endmodule
`default_nettype wire

>>> rtl/mcph_search.sv
// Breadth-first search from every root over the edge memory.
`default_nettype none
module mcph_search import mcph_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire eng_ctl_type       ctl,
   output eng_sts_type            sts,
   output logic [CELL_W-1:0]      edge_addr,
   input  wire logic              edge_data,
   output logic                   hop_we,
   output logic [CELL_W-1:0]      hop_waddr,
   output logic [DIST_W-1:0]      hop_wdata,
   output logic [CELL_W-1:0]      hop_raddr,
   input  wire logic [DIST_W-1:0] hop_rdata,
   output logic                   q_we,
   output logic [NODE_W-1:0]      q_waddr,
   output logic [NODE_W-1:0]      q_wdata,
   output logic [NODE_W-1:0]      q_raddr,
   input  wire logic [NODE_W-1:0] q_rdata
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INIT = 3'd1;
   localparam logic [2:0] S_POP  = 3'd2;
   localparam logic [2:0] S_HEAD = 3'd3;
   localparam logic [2:0] S_ULVL = 3'd4;
   localparam logic [2:0] S_VRD  = 3'd5;
   localparam logic [2:0] S_VEV  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [NODE_W-1:0] r_ff, r_in, v_ff, v_in, u_ff, u_in;
   logic [CNT_W-1:0]  head_ff, head_in, tail_ff, tail_in, n_ff, n_in;
   logic [DIST_W-1:0] du_ff, du_in;
   logic              done_ff, done_in;
   logic              r_last, v_last;

   assign r_last   = ({1'b0, r_ff} == n_ff - CNT_W'(1));
   assign v_last   = ({1'b0, v_ff} == n_ff - CNT_W'(1));
   assign sts.done = done_ff;
   assign sts.ok   = 1'b1;

   always_comb begin
      state_in  = state_ff;
      r_in      = r_ff;
      v_in      = v_ff;
      u_in      = u_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      n_in      = n_ff;
      du_in     = du_ff;
      done_in   = 1'b0;
      edge_addr = {u_ff, v_ff};
      hop_we    = 1'b0;
      hop_waddr = {r_ff, v_ff};
      hop_wdata = (du_ff == HOP_MAX) ? HOP_MAX : du_ff + DIST_W'(1);
      hop_raddr = {r_ff, v_ff};
      q_we      = 1'b0;
      q_waddr   = tail_ff[NODE_W-1:0];
      q_wdata   = v_ff;
      q_raddr   = head_ff[NODE_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               n_in     = ctl.count;
               r_in     = '0;
               v_in     = '0;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            // clear the root's row, root itself at zero, seed the queue
            hop_we    = 1'b1;
            hop_wdata = (v_ff == r_ff) ? '0 : DIST_NONE;
            q_we      = (v_ff == '0);
            q_waddr   = '0;
            q_wdata   = r_ff;
            if (v_last) begin
               head_in  = '0;
               tail_in  = CNT_W'(1);
               state_in = S_POP;
            end else begin
               v_in = v_ff + NODE_W'(1);
            end
         end
         S_POP: begin
            if (head_ff == tail_ff) begin
               if (r_last) begin
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  r_in     = r_ff + NODE_W'(1);
                  v_in     = '0;
                  state_in = S_INIT;
               end
            end else begin
               head_in  = head_ff + CNT_W'(1);
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            u_in      = q_rdata;
            hop_raddr = {r_ff, q_rdata};
            state_in  = S_ULVL;
         end
         S_ULVL: begin
            du_in    = hop_rdata;
            v_in     = '0;
            state_in = S_VRD;
         end
         S_VRD: begin
            state_in = S_VEV;
         end
         default: begin
            if (edge_data && (hop_rdata == DIST_NONE) && (tail_ff < CNT_W'(MAX_NODES))) begin
               hop_we  = 1'b1;
               q_we    = 1'b1;
               tail_in = tail_ff + CNT_W'(1);
            end
            if (v_last) begin
               state_in = S_POP;
            end else begin
               v_in     = v_ff + NODE_W'(1);
               state_in = S_VRD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      r_ff    <= r_in;
      v_ff    <= v_in;
      u_ff    <= u_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      n_ff    <= n_in;
      du_ff   <= du_in;
   end
endmodule
`default_nettype wire

>>> rtl/metric_check_prune_hop_distances_core.sv
// Top level: latency load, solve sequencing, distance reads and response register.
//
//   channel  dir  handshake          payload
//   req_bus  in   valid/ready        func, latency, source_node, target_node
//   rsp_bus  out  valid/ready        possible, distance
//   csr      in   csr_wr_en          csr_wr_data = node_count
//
// Load: written to both latency memories when accepted at a valid position. Read:
// hop memory read, then response register. Solve: sweep in mcph_prune (one triple
// per cycle from two latency memory copies), then, if possible, a breadth-first
// search (each neighbor test reads the edge and hop memories, then evaluates).
// Synchronous reset clears control only; the memories hold garbage until written.
// A new request is taken in idle once the response register is empty or draining.
`default_nettype none
module metric_check_prune_hop_distances_core import mcph_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data,
   mcph_req_if.sink              req_bus,
   mcph_rsp_if.source            rsp_bus
);
   localparam logic [1:0] T_IDLE   = 2'd0;
   localparam logic [1:0] T_READ   = 2'd1;
   localparam logic [1:0] T_PRUNE  = 2'd2;
   localparam logic [1:0] T_SEARCH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CFG_W-1:0]  node_count_ff, node_count_in;
   logic [NODE_W-1:0] load_row_ff, load_row_in, load_col_ff, load_col_in;
   logic              verdict_ff, verdict_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_possible_ff, rsp_possible_in;
   logic [DIST_W-1:0] rsp_distance_ff, rsp_distance_in;

   logic [CNT_W-1:0]  n_eff;
   logic              accept, load_bad;
   logic [NODE_W-1:0] col_next;
   logic [CNT_W-1:0]  row_next;
   logic              lat_we;

   eng_ctl_type       prune_ctl, search_ctl;
   eng_sts_type       prune_sts, search_sts;

   logic [CELL_W-1:0]    lat_a_addr, lat_b_addr;
   logic [LAT_WIDTH-1:0] lat_a_data, lat_b_data;
   logic                 edge_we, edge_wdata, edge_rdata;
   logic [CELL_W-1:0]    edge_waddr, edge_raddr;
   logic                 hop_we;
   logic [CELL_W-1:0]    hop_waddr, hop_raddr, srch_hop_raddr;
   logic [DIST_W-1:0]    hop_wdata, hop_rdata;
   logic                 q_we;
   logic [NODE_W-1:0]    q_waddr, q_wdata, q_raddr, q_rdata;

   // clamp of the node count register into 1..MAX_NODES
   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (int'(node_count_ff) > MAX_NODES) begin
         n_eff = CNT_W'(MAX_NODES);
      end else begin
         n_eff = CNT_W'(node_count_ff);
      end
   end

   assign req_bus.ready = (state_ff == T_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.possible = rsp_possible_ff;
   assign rsp_bus.distance = rsp_distance_ff;

   // load position: lower triangle, row-major, wraps to row 1 after the last pair
   assign load_bad = ({1'b0, load_row_ff} >= n_eff) || (load_col_ff >= load_row_ff);
   assign col_next = load_col_ff + NODE_W'(1);
   assign row_next = {1'b0, load_row_ff} + CNT_W'(1);
   assign lat_we   = accept && (req_bus.func == FUNC_LOAD) && !load_bad;

   assign prune_ctl.start  = accept && (req_bus.func == FUNC_SOLVE);
   assign prune_ctl.count  = n_eff;
   assign search_ctl.start = (state_ff == T_PRUNE) && prune_sts.done && prune_sts.ok;
   assign search_ctl.count = n_eff;

   // idle: hop memory serves distance reads; otherwise it belongs to the search
   assign hop_raddr = (state_ff == T_IDLE) ? {req_bus.source_node, req_bus.target_node}
                                           : srch_hop_raddr;

   always_comb begin
      state_in        = state_ff;
      node_count_in   = node_count_ff;
      load_row_in     = load_row_ff;
      load_col_in     = load_col_ff;
      verdict_in      = verdict_ff;
      rd_ok_in        = rd_ok_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_possible_in = rsp_possible_ff;
      rsp_distance_in = rsp_distance_ff;

      if (csr_wr_en) begin
         node_count_in = csr_wr_data;
         load_row_in   = NODE_W'(1);
         load_col_in   = '0;
         verdict_in    = 1'b0;
      end

      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               priority case (req_bus.func)
                  FUNC_LOAD: begin
                     if (load_bad) begin
                        load_row_in = NODE_W'(1);
                        load_col_in = '0;
                     end else if (col_next >= load_row_ff) begin
                        load_col_in = '0;
                        load_row_in = (row_next >= n_eff) ? NODE_W'(1)
                                                          : row_next[NODE_W-1:0];
                     end else begin
                        load_col_in = col_next;
                     end
                  end
                  FUNC_SOLVE: begin
                     state_in = T_PRUNE;
                  end
                  FUNC_READ: begin
                     rd_ok_in = verdict_ff
                                && ({1'b0, req_bus.source_node} < n_eff)
                                && ({1'b0, req_bus.target_node} < n_eff);
                     state_in = T_READ;
                  end
                  default: begin
                     // unused code: dropped without a response
                  end
               endcase
            end
         end
         T_READ: begin
            rsp_valid_in    = 1'b1;
            rsp_possible_in = verdict_ff;
            rsp_distance_in = rd_ok_ff ? hop_rdata : DIST_NONE;
            state_in        = T_IDLE;
         end
         T_PRUNE: begin
            if (prune_sts.done) begin
               verdict_in = prune_sts.ok;
               if (prune_sts.ok) begin
                  state_in = T_SEARCH;
               end else begin
                  rsp_valid_in    = 1'b1;
                  rsp_possible_in = 1'b0;
                  rsp_distance_in = '0;
                  state_in        = T_IDLE;
               end
            end
         end
         default: begin
            if (search_sts.done) begin
               rsp_valid_in    = 1'b1;
               rsp_possible_in = 1'b1;
               rsp_distance_in = '0;
               state_in        = T_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         node_count_ff <= CFG_W'(1);
         load_row_ff   <= NODE_W'(1);
         load_col_ff   <= '0;
         verdict_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         load_row_ff   <= load_row_in;
         load_col_ff   <= load_col_in;
         verdict_ff    <= verdict_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rd_ok_ff        <= rd_ok_in;
      rsp_possible_ff <= rsp_possible_in;
      rsp_distance_ff <= rsp_distance_in;
   end

   // two copies of the lower triangle so both latencies of a triple are read in the same cycle
   mcph_ram #(.WIDTH(LAT_WIDTH), .DEPTH(CELLS)) u_lat_a (
      .clock   (clock),
      .wr_en   (lat_we),
      .wr_addr (lat_cell(load_row_ff, load_col_ff)),
      .wr_data (req_bus.latency),
      .rd_addr (lat_a_addr),
      .rd_data (lat_a_data)
   );

   mcph_ram #(.WIDTH(LAT_WIDTH), .DEPTH(CELLS)) u_lat_b (
      .clock   (clock),
      .wr_en   (lat_we),
      .wr_addr (lat_cell(load_row_ff, load_col_ff)),
      .wr_data (req_bus.latency),
      .rd_addr (lat_b_addr),
      .rd_data (lat_b_data)
   );

   mcph_ram #(.WIDTH(1), .DEPTH(CELLS)) u_edge (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_waddr),
      .wr_data (edge_wdata),
      .rd_addr (edge_raddr),
      .rd_data (edge_rdata)
   );

   mcph_ram #(.WIDTH(DIST_W), .DEPTH(CELLS)) u_hop (
      .clock   (clock),
      .wr_en   (hop_we),
      .wr_addr (hop_waddr),
      .wr_data (hop_wdata),
      .rd_addr (hop_raddr),
      .rd_data (hop_rdata)
   );

   mcph_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   mcph_prune u_prune (
      .clock      (clock),
      .reset      (reset),
      .ctl        (prune_ctl),
      .sts        (prune_sts),
      .lat_a_addr (lat_a_addr),
      .lat_a_data (lat_a_data),
      .lat_b_addr (lat_b_addr),
      .lat_b_data (lat_b_data),
      .edge_we    (edge_we),
      .edge_addr  (edge_waddr),
      .edge_data  (edge_wdata)
   );

   mcph_search u_search (
      .clock     (clock),
      .reset     (reset),
      .ctl       (search_ctl),
      .sts       (search_sts),
      .edge_addr (edge_raddr),
      .edge_data (edge_rdata),
      .hop_we    (hop_we),
      .hop_waddr (hop_waddr),
      .hop_wdata (hop_wdata),
      .hop_raddr (srch_hop_raddr),
      .hop_rdata (hop_rdata),
      .q_we      (q_we),
      .q_waddr   (q_waddr),
      .q_wdata   (q_wdata),
      .q_raddr   (q_raddr),
      .q_rdata   (q_rdata)
   );

   // requests are only taken while no solve or read is in flight
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> (state_ff == T_IDLE))
      else $error("request ready outside idle");

   // load position always names a lower-triangle cell
   a_load_pos: assert property (@(posedge clock) disable iff (reset)
      load_col_ff < load_row_ff)
      else $error("load position left the lower triangle");

   // an impossible verdict yields distance 0 (solve) or -1 (read)
   a_impossible_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_possible_ff) |->
         ((rsp_distance_ff == '0) || (rsp_distance_ff == DIST_NONE)))
      else $error("bad distance with impossible verdict");

   // a solve start puts the sequencer into the sweep
   a_solve_start: assert property (@(posedge clock) disable iff (reset)
      prune_ctl.start |=> (state_ff == T_PRUNE))
      else $error("solve accepted but sweep not running");
endmodule
`default_nettype wire
